// ----- design/cle_pkg.sv -----
// Shared types and character codes for the console line editor.
`default_nettype none

package cle_pkg;

    // Default depth of the line store.
    localparam int BUFFER_SIZE_DEF = 64;

    // Input transaction kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TAKE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Console character codes.
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [5:0] read_index;
    } item_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       line_ready;
        logic       rejected;
        logic       take_ok;
        logic [5:0] line_length;
        logic [7:0] read_char;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ----- design/cle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/console_line_editor_echo_top.sv -----
// Console line editor top level: line store, cursor, echo sequencing.
// An accepted transaction is registered in the decode stage, and its results
// are loaded into the result sequencer when it fires, which can be held off.
// Results leave one per cycle through the single result register while
// result_stall is low; an item makes 1 to 3 results, set by its echo bytes.
// Reset (rst_n low, asynchronous) empties the line and clears the pending flag;
// the line store itself is not cleared and holds old data until written.
`default_nettype none

module console_line_editor_echo_top #(
    parameter int BUFFER_SIZE = cle_pkg::BUFFER_SIZE_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire cle_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output cle_pkg::result_t     result
);

    import cle_pkg::*;

    // The cursor never exceeds BUFFER_SIZE-2, so the address width covers it.
    localparam int CW = $clog2(BUFFER_SIZE);
    localparam logic [CW-1:0] FILL_LIMIT = CW'(BUFFER_SIZE - 2);

    // Decode stage: the accepted transaction waits here while the store read
    // that it issued at accept time completes.
    item_t           item_reg;
    logic            item_valid_reg;
    logic            item_valid_next;

    // Line state.
    logic [CW-1:0]   cursor_reg;
    logic [CW-1:0]   cursor_next;
    logic            pending_reg;
    logic            pending_next;

    // Result sequencer: up to three results shift out through slot 0.
    result_t         res_reg [3];
    result_t         res_next [3];
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;

    // Bypass for a store write that lands in the same cycle as the read.
    logic            byp_hit_reg;
    logic [7:0]      byp_data_reg;

    logic            accept;
    logic            take;
    logic            fire;
    logic            wr_en;
    logic [CW-1:0]   rd_addr;
    logic [7:0]      ram_rdata;
    logic [7:0]      stored_char;
    logic            in_range;
    logic            printable;
    result_t         gen [3];
    logic [1:0]      gen_cnt;

    // Handshake control. The decode stage may move into the result sequencer
    // when the sequencer is empty, or when its final result leaves this cycle.
    assign result_valid = (cnt_reg != 2'd0);
    assign result       = res_reg[0];
    assign take         = result_valid && !result_stall;
    assign fire         = item_valid_reg
                          && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take));
    assign item_stall   = item_valid_reg && !fire;
    assign accept       = item_valid && !item_stall;

    assign rd_addr = CW'(item.read_index);

    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_SIZE)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cursor_reg),
        .wr_data (item_reg.data_byte),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign stored_char = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign in_range    = (32'(item_reg.read_index) < 32'(BUFFER_SIZE));
    assign printable   = (item_reg.data_byte >= CH_SP) && (item_reg.data_byte != CH_DEL);

    // Decode of one transaction into its results and the state update.
    always_comb
    begin
        cursor_next  = cursor_reg;
        pending_next = pending_reg;
        wr_en        = 1'b0;
        gen[0]       = '0;
        gen[1]       = '0;
        gen[2]       = '0;
        gen_cnt      = 2'd1;
        gen[0].last  = 1'b1;

        unique case (item_reg.kind)
            KIND_BYTE:
            begin
                priority if (pending_reg)
                begin
                    // A finished line is still waiting: drop the byte.
                    gen[0].rejected = 1'b1;
                end
                else if ((item_reg.data_byte == CH_BS) || (item_reg.data_byte == CH_DEL))
                begin
                    // Rubout: always echo BS, SP, BS, even on an empty line.
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - CW'(1);
                    end
                    gen[0].last       = 1'b0;
                    gen[0].echo_valid = 1'b1;
                    gen[0].echo_byte  = CH_BS;
                    gen[1].echo_valid = 1'b1;
                    gen[1].echo_byte  = CH_SP;
                    gen[2].echo_valid = 1'b1;
                    gen[2].echo_byte  = CH_BS;
                    gen[2].last       = 1'b1;
                    gen_cnt           = 2'd3;
                end
                else if ((item_reg.data_byte == CH_LF) || (item_reg.data_byte == CH_CR))
                begin
                    pending_next      = 1'b1;
                    gen[0].last       = 1'b0;
                    gen[0].echo_valid = 1'b1;
                    gen[0].echo_byte  = CH_LF;
                    gen[1].echo_valid = 1'b1;
                    gen[1].echo_byte  = CH_CR;
                    gen[1].line_ready = 1'b1;
                    gen[1].last       = 1'b1;
                    gen_cnt           = 2'd2;
                end
                else if (cursor_reg < FILL_LIMIT)
                begin
                    // Room left: store; echo only printable characters.
                    wr_en       = 1'b1;
                    cursor_next = cursor_reg + CW'(1);
                    if (printable)
                    begin
                        gen[0].echo_valid = 1'b1;
                        gen[0].echo_byte  = item_reg.data_byte;
                    end
                end
                else if (printable)
                begin
                    // Line full: echo the character, then back over it.
                    gen[0].last       = 1'b0;
                    gen[0].echo_valid = 1'b1;
                    gen[0].echo_byte  = item_reg.data_byte;
                    gen[1].echo_valid = 1'b1;
                    gen[1].echo_byte  = CH_BS;
                    gen[1].last       = 1'b1;
                    gen_cnt           = 2'd2;
                end
                else
                begin
                    gen[0].echo_valid = 1'b1;
                    gen[0].echo_byte  = CH_BS;
                end
            end
            KIND_TAKE:
            begin
                if (pending_reg)
                begin
                    gen[0].take_ok     = 1'b1;
                    gen[0].line_length = 6'(cursor_reg);
                    cursor_next        = '0;
                    pending_next       = 1'b0;
                end
            end
            KIND_READ:
            begin
                if (in_range)
                begin
                    gen[0].read_char = stored_char;
                end
            end
            default:
            begin
                // Unused kind: a bare final result, no state change.
            end
        endcase

        if (!fire)
        begin
            cursor_next  = cursor_reg;
            pending_next = pending_reg;
            wr_en        = 1'b0;
        end
    end

    // Result sequencer update: load a new set or shift one result out.
    always_comb
    begin
        res_next[0] = res_reg[0];
        res_next[1] = res_reg[1];
        res_next[2] = res_reg[2];
        cnt_next    = cnt_reg;
        if (fire)
        begin
            res_next[0] = gen[0];
            res_next[1] = gen[1];
            res_next[2] = gen[2];
            cnt_next    = gen_cnt;
        end
        else if (take)
        begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cursor_reg     <= '0;
            pending_reg    <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cursor_reg     <= cursor_next;
            pending_reg    <= pending_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        res_reg[0] <= res_next[0];
        res_reg[1] <= res_next[1];
        res_reg[2] <= res_next[2];
        if (accept)
        begin
            item_reg     <= item;
            byp_hit_reg  <= wr_en && (cursor_reg == rd_addr);
            byp_data_reg <= item_reg.data_byte;
        end
    end

    // The cursor never runs past the fill limit.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= FILL_LIMIT)
        else $error("cursor beyond fill limit");

    // The final-result mark sits exactly on the last queued result.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (cnt_reg == 2'd1)))
        else $error("last mark out of place");

    // A line-ready result is only offered while the line is pending.
    a_ready_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.line_ready) |-> pending_reg)
        else $error("line ready without pending line");

endmodule

`default_nettype wire
